FILE: src/dbq_pkg.sv
`timescale 1ns / 1ps
// dbq_pkg: constants, tables, types and the scale function of the dct block quantizer
// no dependencies; used by every module of the block but dbq_ram through scoped names

package dbq_pkg;

    localparam int BLOCK_ELEMENTS = 64;
    localparam int POS_W          = $clog2(BLOCK_ELEMENTS);
    localparam int COEF_W         = 16;
    localparam int QUAL_W         = 7;
    localparam int BASE_W         = 7;
    localparam int SCALE_W        = 13;
    localparam int STEP_W         = 13;
    localparam int PROD_W         = BASE_W + SCALE_W;
    localparam int RECIP_W        = 21;
    localparam int RECIP_SHIFT    = 27;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**PROD_W
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);

    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = COEF_W / DIV_BITS;

    localparam int OUT_DEPTH = 16;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    localparam logic [QUAL_W-1:0]  QUAL_RESET     = 7'd1;
    localparam logic [QUAL_W-1:0]  QUAL_MID       = 7'd50;
    localparam logic [QUAL_W-1:0]  QUAL_MAX       = 7'd100;
    localparam logic [7:0]         SCALE_HIGH_TOP = 8'd200;
    localparam logic [STEP_W-1:0]  STEP_MIN       = 13'd1;

    localparam logic DIR_QUANTIZE   = 1'b0;
    localparam logic DIR_DEQUANTIZE = 1'b1;

    typedef enum logic {
        REG_QUALITY   = 1'b0,
        REG_DIRECTION = 1'b1
    } reg_idx_t;

    // luminance base table, row-major
    localparam logic [BASE_W-1:0] BASE_TABLE [0:BLOCK_ELEMENTS-1] = '{
        7'd16,  7'd11,  7'd10,  7'd16,  7'd24,  7'd40,  7'd51,  7'd61,
        7'd12,  7'd12,  7'd14,  7'd19,  7'd26,  7'd58,  7'd60,  7'd55,
        7'd14,  7'd13,  7'd16,  7'd24,  7'd40,  7'd57,  7'd69,  7'd56,
        7'd14,  7'd17,  7'd22,  7'd29,  7'd51,  7'd87,  7'd80,  7'd62,
        7'd18,  7'd22,  7'd37,  7'd56,  7'd68,  7'd109, 7'd103, 7'd77,
        7'd24,  7'd35,  7'd55,  7'd64,  7'd81,  7'd104, 7'd113, 7'd92,
        7'd49,  7'd64,  7'd78,  7'd87,  7'd103, 7'd121, 7'd120, 7'd101,
        7'd72,  7'd92,  7'd95,  7'd98,  7'd112, 7'd100, 7'd103, 7'd99
    };

    // 5000 / q for q below 50, quality zero taken as one
    localparam logic [SCALE_W-1:0] SCALE_LOW_LUT [0:QUAL_MID-1] = '{
        13'd5000, 13'd5000, 13'd2500, 13'd1666, 13'd1250, 13'd1000, 13'd833,  13'd714,
        13'd625,  13'd555,  13'd500,  13'd454,  13'd416,  13'd384,  13'd357,  13'd333,
        13'd312,  13'd294,  13'd277,  13'd263,  13'd250,  13'd238,  13'd227,  13'd217,
        13'd208,  13'd200,  13'd192,  13'd185,  13'd178,  13'd172,  13'd166,  13'd161,
        13'd156,  13'd151,  13'd147,  13'd142,  13'd138,  13'd135,  13'd131,  13'd128,
        13'd125,  13'd121,  13'd119,  13'd116,  13'd113,  13'd111,  13'd108,  13'd106,
        13'd104,  13'd102
    };

    localparam logic [SCALE_W-1:0] SCALE_RESET = 13'd5000;

    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  addr;
        logic [STEP_W-1:0] data;
    } step_wr_t;

    typedef struct packed {
        logic              neg;
        logic              dir;
        logic [COEF_W-1:0] prod;
    } div_side_t;

    typedef struct packed {
        logic [STEP_W-1:0] rem;
        logic [COEF_W-1:0] dq;
        logic [STEP_W-1:0] step;
        div_side_t         side;
    } div_lane_t;

    function automatic logic [SCALE_W-1:0] scale_for(input logic [QUAL_W-1:0] q);
        logic [SCALE_W-1:0] s;
        if (q >= QUAL_MAX) begin
            s = '0;
        end else if (q >= QUAL_MID) begin
            s = {{(SCALE_W-8){1'b0}}, SCALE_HIGH_TOP - {q, 1'b0}};
        end else begin
            s = SCALE_LOW_LUT[q[5:0]];
        end
        return s;
    endfunction

endpackage

FILE: src/dbq_ram.sv
`timescale 1ns / 1ps
// dbq_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies

module dbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/dbq_step_fill.sv
`timescale 1ns / 1ps
// dbq_step_fill: sweeps the step table, one entry per cycle, after reset and quality writes
// depends on dbq_pkg (base table, reciprocal of 100, write struct)

module dbq_step_fill (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [dbq_pkg::SCALE_W-1:0]  scale,
    output logic                         busy,
    output dbq_pkg::step_wr_t            step_wr
);

    logic [dbq_pkg::POS_W:0]                       cnt_reg, cnt_next;
    logic                                          issuing;
    logic                                          va_reg, vb_reg;
    logic [dbq_pkg::POS_W-1:0]                     a_idx_reg, b_idx_reg;
    logic [dbq_pkg::PROD_W-1:0]                    a_prod_reg, a_prod_next;
    logic [dbq_pkg::STEP_W-1:0]                    b_quot_reg, b_quot_next;
    logic [dbq_pkg::PROD_W+dbq_pkg::RECIP_W-1:0]   b_full;

    assign issuing = !cnt_reg[dbq_pkg::POS_W];

    always_comb begin
        if (start) begin
            cnt_next = '0;
        end else if (issuing) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    // base * scale, then divide by 100 through the reciprocal
    always_comb begin
        a_prod_next = {{(dbq_pkg::PROD_W-dbq_pkg::BASE_W){1'b0}},
                       dbq_pkg::BASE_TABLE[cnt_reg[dbq_pkg::POS_W-1:0]]}
                    * {{(dbq_pkg::PROD_W-dbq_pkg::SCALE_W){1'b0}}, scale};
        b_full      = {{dbq_pkg::RECIP_W{1'b0}}, a_prod_reg}
                    * {{dbq_pkg::PROD_W{1'b0}}, dbq_pkg::RECIP_100};
        b_quot_next = b_full[dbq_pkg::RECIP_SHIFT +: dbq_pkg::STEP_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            va_reg  <= issuing;
            vb_reg  <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_idx_reg  <= cnt_reg[dbq_pkg::POS_W-1:0];
        a_prod_reg <= a_prod_next;
        b_idx_reg  <= a_idx_reg;
        b_quot_reg <= b_quot_next;
    end

    always_comb begin
        step_wr.we   = vb_reg;
        step_wr.addr = b_idx_reg;
        step_wr.data = (b_quot_reg == '0) ? dbq_pkg::STEP_MIN : b_quot_reg;
    end

    assign busy = issuing || va_reg || vb_reg;

endmodule

FILE: src/dbq_div.sv
`timescale 1ns / 1ps
// dbq_div: pipelined restoring divider, two quotient bits per stage, carries item sideband
// depends on dbq_pkg (lane struct, stage counts)

module dbq_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  dbq_pkg::div_lane_t in_lane,
    output logic               out_valid,
    output dbq_pkg::div_lane_t out_lane
);

    dbq_pkg::div_lane_t              lane_reg  [0:dbq_pkg::DIV_STAGES-1];
    dbq_pkg::div_lane_t              lane_next [0:dbq_pkg::DIV_STAGES-1];
    logic [dbq_pkg::DIV_STAGES-1:0]  vld_reg, vld_next;

    function automatic dbq_pkg::div_lane_t div_step(input dbq_pkg::div_lane_t a);
        dbq_pkg::div_lane_t       r;
        logic [dbq_pkg::STEP_W:0] trial;
        r = a;
        for (int b = 0; b < dbq_pkg::DIV_BITS; b++) begin
            trial = {r.rem, r.dq[dbq_pkg::COEF_W-1]};
            r.dq  = {r.dq[dbq_pkg::COEF_W-2:0], 1'b0};
            if (trial >= {1'b0, r.step}) begin
                trial   = trial - {1'b0, r.step};
                r.dq[0] = 1'b1;
            end
            r.rem = trial[dbq_pkg::STEP_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        lane_next[0] = div_step(in_lane);
        for (int s = 1; s < dbq_pkg::DIV_STAGES; s++) begin
            lane_next[s] = div_step(lane_reg[s-1]);
        end
        vld_next = {vld_reg[dbq_pkg::DIV_STAGES-2:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < dbq_pkg::DIV_STAGES; s++) begin
            lane_reg[s] <= lane_next[s];
        end
    end

    assign out_valid = vld_reg[dbq_pkg::DIV_STAGES-1];
    assign out_lane  = lane_reg[dbq_pkg::DIV_STAGES-1];

endmodule

FILE: src/dct_block_quantizer_top.sv
`timescale 1ns / 1ps
// dct_block_quantizer_top: quality-scaled quantizer / dequantizer for 8x8 dct coefficients
// depends on dbq_pkg, dbq_ram, dbq_step_fill, dbq_div
//
// Usage:
// Input items (s_coefficient, s_position) enter on a valid/ready channel; each gives one
// result item (m_value) on the m_ channel, in order. quality and direction are set over
// the apb port (quality at 0x0, direction at 0x4) while no items are in flight.
// The 64 step sizes live in a synchronous ram that is refilled, one entry per cycle,
// after reset and after each quality write; s_ready stays low meanwhile.
// From accept to m_valid an item passes the ram read at the accept edge, eight
// divider stages of two quotient bits each (the dequantize product forms ahead of the
// first) and one output queue write. Dequantize results take the same path, so order is kept.
// Throughput is one item per cycle while s_ready is high, set by the pipelined divider.
// Results wait in a 16-item output queue; a credit count covers the queue and the
// pipeline, so a stalled receiver only drops s_ready once 16 items are outstanding.
// Reset is synchronous and active low: quality 1, direction quantize, queue empty.

module dct_block_quantizer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [dbq_pkg::COEF_W-1:0]  s_coefficient,
    input  logic        [dbq_pkg::POS_W-1:0]   s_position,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [dbq_pkg::COEF_W-1:0]  m_value,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dbq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dbq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dbq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    // configuration
    dbq_pkg::reg_idx_t                 reg_idx;
    logic                              cfg_wr, quality_wr;
    logic [dbq_pkg::QUAL_W-1:0]        quality_reg, quality_next;
    logic                              direction_reg, direction_next;
    logic [dbq_pkg::SCALE_W-1:0]       scale_reg, scale_next;

    // step table
    logic                              fill_busy;
    dbq_pkg::step_wr_t                 step_wr;
    logic [dbq_pkg::STEP_W-1:0]        step_rdata;

    // input stage
    logic                              s_accept;
    logic                              in_vld_reg;
    logic [dbq_pkg::COEF_W-1:0]        in_mag_reg, in_mag_next;
    logic                              in_neg_reg, in_dir_reg;

    // divider
    dbq_pkg::div_lane_t                div_in, div_out;
    logic                              div_out_valid;
    logic [dbq_pkg::COEF_W+dbq_pkg::STEP_W-1:0] prod_full;
    logic [dbq_pkg::COEF_W-1:0]        res_mag, res_value;

    // output queue
    logic [dbq_pkg::COEF_W-1:0]        fifo_mem_reg [0:dbq_pkg::OUT_DEPTH-1];
    logic [dbq_pkg::OUT_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [dbq_pkg::OUT_CNT_W-1:0]     fifo_cnt_reg, fifo_cnt_next;
    logic [dbq_pkg::OUT_CNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic                              m_pop;

    // apb port
    assign pready     = 1'b1;
    assign reg_idx    = dbq_pkg::reg_idx_t'(paddr[2]);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign quality_wr = cfg_wr && (reg_idx == dbq_pkg::REG_QUALITY);

    always_comb begin
        quality_next   = quality_reg;
        direction_next = direction_reg;
        scale_next     = scale_reg;
        if (cfg_wr) begin
            case (reg_idx)
                dbq_pkg::REG_QUALITY: begin
                    quality_next = pwdata[dbq_pkg::QUAL_W-1:0];
                    scale_next   = dbq_pkg::scale_for(pwdata[dbq_pkg::QUAL_W-1:0]);
                end
                dbq_pkg::REG_DIRECTION: begin
                    direction_next = pwdata[0];
                end
                default: begin
                    quality_next = quality_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dbq_pkg::REG_QUALITY: begin
                prdata = {{(dbq_pkg::APB_DATA_W-dbq_pkg::QUAL_W){1'b0}}, quality_reg};
            end
            dbq_pkg::REG_DIRECTION: begin
                prdata = {{(dbq_pkg::APB_DATA_W-1){1'b0}}, direction_reg};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quality_reg   <= dbq_pkg::QUAL_RESET;
            direction_reg <= dbq_pkg::DIR_QUANTIZE;
            scale_reg     <= dbq_pkg::SCALE_RESET;
        end else begin
            quality_reg   <= quality_next;
            direction_reg <= direction_next;
            scale_reg     <= scale_next;
        end
    end

    // step table fill and storage
    dbq_step_fill u_fill (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (quality_wr),
        .scale   (scale_reg),
        .busy    (fill_busy),
        .step_wr (step_wr)
    );

    dbq_ram #(
        .WIDTH (dbq_pkg::STEP_W),
        .DEPTH (dbq_pkg::BLOCK_ELEMENTS)
    ) u_step_ram (
        .aclk  (aclk),
        .we    (step_wr.we),
        .waddr (step_wr.addr),
        .wdata (step_wr.data),
        .raddr (s_position),
        .rdata (step_rdata)
    );

    // input stage: ram read runs in parallel with magnitude capture
    assign s_ready  = !fill_busy && (out_cnt_reg != dbq_pkg::OUT_CNT_W'(dbq_pkg::OUT_DEPTH));
    assign s_accept = s_valid && s_ready;

    assign in_mag_next = s_coefficient[dbq_pkg::COEF_W-1] ? (~s_coefficient + 1'b1)
                                                           : s_coefficient;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        in_mag_reg <= in_mag_next;
        in_neg_reg <= s_coefficient[dbq_pkg::COEF_W-1];
        in_dir_reg <= direction_reg;
    end

    // dequantize product, wrapped to the field width
    assign prod_full = {{dbq_pkg::STEP_W{1'b0}}, in_mag_reg}
                     * {{dbq_pkg::COEF_W{1'b0}}, step_rdata};

    always_comb begin
        div_in.rem       = '0;
        div_in.dq        = in_mag_reg;
        div_in.step      = step_rdata;
        div_in.side.neg  = in_neg_reg;
        div_in.side.dir  = in_dir_reg;
        div_in.side.prod = prod_full[dbq_pkg::COEF_W-1:0];
    end

    dbq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_vld_reg),
        .in_lane   (div_in),
        .out_valid (div_out_valid),
        .out_lane  (div_out)
    );

    always_comb begin
        res_mag   = (div_out.side.dir == dbq_pkg::DIR_DEQUANTIZE) ? div_out.side.prod
                                                                   : div_out.dq;
        res_value = div_out.side.neg ? (~res_mag + 1'b1) : res_mag;
    end

    // output queue and credit count
    assign m_valid = (fifo_cnt_reg != '0);
    assign m_value = $signed(fifo_mem_reg[rd_ptr_reg]);
    assign m_pop   = m_valid && m_ready;

    always_comb begin
        wr_ptr_next   = div_out_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next   = m_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg + {{(dbq_pkg::OUT_CNT_W-1){1'b0}}, div_out_valid}
                                     - {{(dbq_pkg::OUT_CNT_W-1){1'b0}}, m_pop};
        out_cnt_next  = out_cnt_reg + {{(dbq_pkg::OUT_CNT_W-1){1'b0}}, s_accept}
                                    - {{(dbq_pkg::OUT_CNT_W-1){1'b0}}, m_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            out_cnt_reg  <= '0;
        end else begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            fifo_cnt_reg <= fifo_cnt_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_out_valid) begin
            fifo_mem_reg[wr_ptr_reg] <= res_value;
        end
    end

    // credit count never exceeds the queue depth
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= dbq_pkg::OUT_CNT_W'(dbq_pkg::OUT_DEPTH))
        else $error("outstanding item count above queue depth");

    // queued items are a subset of outstanding items
    a_queue_in_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= out_cnt_reg)
        else $error("output queue holds more items than are outstanding");

    // divider never delivers into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        div_out_valid |-> (fifo_cnt_reg != dbq_pkg::OUT_CNT_W'(dbq_pkg::OUT_DEPTH)))
        else $error("item written into full output queue");

    // a quality write closes the input while the step table refills
    a_fill_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        quality_wr |=> !s_ready)
        else $error("input open during step table refill");

endmodule
